### design/kmp_pkg.sv
// Shared constants, types and command/status structs for the KMP next-table builder.
`timescale 1ns / 1ps

package kmp_pkg;

  localparam int MAX_PATTERN = 256;
  localparam int SYMBOL_BITS = 8;

  localparam int IN_SYMBOL_W = 8;
  localparam int FALLBACK_W  = 9;

  localparam int ADDR_W = $clog2(MAX_PATTERN);
  localparam int POS_W  = ADDR_W + 1;
  localparam int IDX_W  = ADDR_W + 1;

  typedef logic [POS_W-1:0]         pos_t;
  typedef logic signed [IDX_W-1:0]  idx_t;
  typedef logic [SYMBOL_BITS-1:0]   sym_t;
  typedef logic [ADDR_W-1:0]        addr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIRST,
    ST_WALK,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic set_entry;
    logic step;
    logic rd_walk;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic jneg;
    logic match;
    logic nj_neg;
  } status_t;

endpackage

### design/kmp_next_table_builder.sv
// Top level of the KMP next-table builder: controller plus datapath.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid/in_stall    in_symbol[7:0], in_last
//   out_     output     out_valid/out_stall  out_fallback[8:0] (signed), out_full_res
//
// An item passes through accept, first compare and hand-off when its first compare
// settles the walk, and through one further step back along the stored entries for
// every failed compare that does not end the walk; a full store or a negative walk
// index goes from accept straight to hand-off. Each step is one registered read of the two stores.
// Reset (rst_n, synchronous, active low) clears the position to zero and the walk
// index to minus one; the stores need no clearing as an entry is only read after
// it was written in the same pattern.
// The result sits in an output register, so a new item is taken while the previous
// result is still stalled; only the hand-off cycle waits for that register to free.
`timescale 1ns / 1ps

module kmp_next_table_builder (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [kmp_pkg::IN_SYMBOL_W-1:0]       in_symbol,
  input  logic                                  in_last,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [kmp_pkg::FALLBACK_W-1:0] out_fallback,
  output logic                                  out_full_res
);

  kmp_pkg::cmd_t    cmd;
  kmp_pkg::status_t sts;

  // The controller decides and holds the state, the datapath holds the stores, position, walk index and results.
  kmp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kmp_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_symbol   (in_symbol),
    .in_last     (in_last),
    .cmd         (cmd),
    .sts         (sts),
    .out_fallback(out_fallback),
    .out_full_res(out_full_res)
  );

endmodule

### design/kmp_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module kmp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/kmp_ctrl.sv
// Controller state machine: sequences accept, first compare, fallback walk and result hand-off.
`timescale 1ns / 1ps

module kmp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  kmp_pkg::status_t sts,
  output kmp_pkg::cmd_t    cmd
);

  kmp_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kmp_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      kmp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.full || sts.jneg) begin
            state_nxt = kmp_pkg::ST_FINISH;
          end else begin
            state_nxt = kmp_pkg::ST_FIRST;
          end
        end
      end
      kmp_pkg::ST_FIRST, kmp_pkg::ST_WALK: begin
        cmd.set_entry = (state_r == kmp_pkg::ST_FIRST);
        cmd.rd_walk   = 1'b1;
        if (sts.match) begin
          state_nxt = kmp_pkg::ST_FINISH;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = sts.nj_neg ? kmp_pkg::ST_FINISH : kmp_pkg::ST_WALK;
        end
      end
      kmp_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = kmp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = kmp_pkg::ST_IDLE;
    endcase
    out_valid_nxt = cmd.finish | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;

endmodule

### design/kmp_dpath.sv
// Datapath: pattern and next-entry stores, position, walk index and result registers.
`timescale 1ns / 1ps

module kmp_dpath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [kmp_pkg::IN_SYMBOL_W-1:0]    in_symbol,
  input  logic                               in_last,
  input  kmp_pkg::cmd_t                      cmd,
  output kmp_pkg::status_t                   sts,
  output logic signed [kmp_pkg::FALLBACK_W-1:0] out_fallback,
  output logic                               out_full_res
);

  kmp_pkg::pos_t  pos_r, pos_nxt;
  kmp_pkg::idx_t  walk_r, walk_nxt;
  kmp_pkg::idx_t  j_r, entry_r;
  kmp_pkg::sym_t  sym_r;
  logic           last_r, full_r;
  logic signed [kmp_pkg::FALLBACK_W-1:0] out_fallback_r;
  logic           out_full_r;

  kmp_pkg::idx_t  jclamp, nj, f_rd;
  kmp_pkg::sym_t  p_rd;
  kmp_pkg::addr_t rd_addr;
  logic           full_now;

  // A walk index at or beyond the position cannot be valid and restarts at -1.
  assign jclamp   = ($signed({1'b0, pos_r}) <= $signed({walk_r[kmp_pkg::IDX_W-1], walk_r}))
                    ? '1 : walk_r;
  assign nj       = (f_rd >= j_r) ? '1 : f_rd;
  assign full_now = (pos_r >= kmp_pkg::POS_W'(kmp_pkg::MAX_PATTERN));
  assign rd_addr  = cmd.rd_walk ? nj[kmp_pkg::ADDR_W-1:0] : jclamp[kmp_pkg::ADDR_W-1:0];

  assign sts.full   = full_now;
  assign sts.jneg   = jclamp[kmp_pkg::IDX_W-1];
  assign sts.match  = (p_rd == sym_r);
  assign sts.nj_neg = nj[kmp_pkg::IDX_W-1];

  kmp_ram #(
    .WIDTH(kmp_pkg::SYMBOL_BITS),
    .DEPTH(kmp_pkg::MAX_PATTERN)
  ) u_pat_ram (
    .clk    (clk),
    .wr_en  (cmd.finish & ~full_r),
    .wr_addr(pos_r[kmp_pkg::ADDR_W-1:0]),
    .wr_data(sym_r),
    .rd_addr(rd_addr),
    .rd_data(p_rd)
  );

  kmp_ram #(
    .WIDTH(kmp_pkg::IDX_W),
    .DEPTH(kmp_pkg::MAX_PATTERN)
  ) u_fb_ram (
    .clk    (clk),
    .wr_en  (cmd.finish & ~full_r),
    .wr_addr(pos_r[kmp_pkg::ADDR_W-1:0]),
    .wr_data(entry_r),
    .rd_addr(rd_addr),
    .rd_data(f_rd)
  );

  always_comb begin
    pos_nxt  = pos_r;
    walk_nxt = walk_r;
    if (cmd.finish) begin
      if (!full_r) begin
        pos_nxt  = pos_r + 1'b1;
        walk_nxt = j_r + kmp_pkg::idx_t'(1);
      end
      if (last_r) begin
        pos_nxt  = '0;
        walk_nxt = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      walk_r <= '1;
    end else begin
      pos_r  <= pos_nxt;
      walk_r <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sym_r   <= kmp_pkg::SYMBOL_BITS'(in_symbol);
      last_r  <= in_last;
      full_r  <= full_now;
      j_r     <= jclamp;
      entry_r <= '1;
    end else begin
      if (cmd.set_entry) begin
        entry_r <= sts.match ? f_rd : j_r;
      end
      if (cmd.step) begin
        j_r <= nj;
      end
    end
    if (cmd.finish) begin
      out_fallback_r <= full_r ? '0 : kmp_pkg::FALLBACK_W'(entry_r);
      out_full_r     <= full_r;
    end
  end

  assign out_fallback = out_fallback_r;
  assign out_full_res = out_full_r;

endmodule

### design/kmp_checker.sv
// Port-level checker for the KMP next-table builder, bound to the top level.
`timescale 1ns / 1ps

module kmp_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [kmp_pkg::FALLBACK_W-1:0] out_fallback,
  input logic                                  out_full_res
);

  // One item at a time: the block is busy in the cycle after taking an item.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken on two consecutive cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_fallback) && $stable(out_full_res))
    else $error("stalled result changed");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_full_res |-> out_fallback == '0)
    else $error("full result carries a non-zero entry");

  a_entry_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_full_res |-> !out_fallback[kmp_pkg::FALLBACK_W-1] || out_fallback == '1)
    else $error("negative entry other than minus one");

endmodule

bind kmp_next_table_builder kmp_checker u_kmp_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_fallback(out_fallback),
  .out_full_res(out_full_res)
);
